// ===== design/teq_pkg.sv =====
// Package for the three-band peaking EQ response pipeline.
// Holds widths, register codes and the constant tables built at elaboration.
// No dependencies.
package teq_pkg;

	localparam int POINT_COUNT = 100;
	localparam int NSEC        = 3;
	localparam int NLANE       = 2 * NSEC;

	// pipeline shape: squaring stages per log2 lane, total register stages
	localparam int NSQ  = 16;
	localparam int LAST = 29;

	localparam int IDXW  = 7;
	localparam int GAINW = 9;
	localparam int LFW   = 15;
	localparam int RESPW = 14;
	localparam int FQW   = 23;
	localparam int G2W   = 25;
	localparam int FCW   = 15;
	localparam int BWW   = 16;
	localparam int DW    = 46;
	localparam int PW    = 47;
	localparam int NRMW  = 18;
	localparam int SQW   = 36;
	localparam int DENW  = 53;
	localparam int NW    = 62;
	localparam int TBW   = 6;
	localparam int MW    = 31;
	localparam int FRW   = 16;
	localparam int LGW   = TBW + FRW;
	localparam int SECW  = LGW + 1;
	localparam int SUMW  = SECW + 2;
	localparam int CPW   = 49;
	localparam int CMW   = 17;

	localparam int CFG_IW = 3;
	localparam int CFG_DW = 16;

	typedef enum logic [CFG_IW-1:0] {
		REG_BASS_CENTER   = 3'd0,
		REG_BASS_WIDTH    = 3'd1,
		REG_MID_CENTER    = 3'd2,
		REG_MID_WIDTH     = 3'd3,
		REG_TREBLE_CENTER = 3'd4,
		REG_TREBLE_WIDTH  = 3'd5
	} cfg_reg_t;

	localparam logic [FCW-1:0] BASS_CENTER_RST   = 15'd100;
	localparam logic [BWW-1:0] BASS_WIDTH_RST    = 16'd200;
	localparam logic [FCW-1:0] MID_CENTER_RST    = 15'd500;
	localparam logic [BWW-1:0] MID_WIDTH_RST     = 16'd1000;
	localparam logic [FCW-1:0] TREBLE_CENTER_RST = 15'd5000;
	localparam logic [BWW-1:0] TREBLE_WIDTH_RST  = 16'd10000;

	localparam logic [63:0] SPAN           = 64'(POINT_COUNT - 1);
	localparam logic [63:0] LOG10_2000_Q28 = 64'd886113492;
	localparam logic [63:0] LOG2_10_Q28    = 64'd891723283;
	localparam logic [63:0] LOG2_10_Q16    = 64'd217706;
	localparam logic [24:0] CENTI_PER_L2   = 25'd19728302;
	localparam logic [CMW-1:0] SAT_CENTI   = 17'd6000;
	localparam logic [CPW-1:0] CENTI_RND   = 49'd1 << 31;

	localparam logic [63:0] POW2_FRAC_Q30 [16] = '{
		64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
		64'd1097253708, 64'd1085434106, 64'd1079572352, 64'd1076653033,
		64'd1075196443, 64'd1074468888, 64'd1074105294, 64'd1073923544,
		64'd1073832680, 64'd1073787251, 64'd1073764537, 64'd1073753181
	};

	typedef logic [FQW-1:0] fq8_tab_t [128];
	typedef logic [LFW-1:0] lf_tab_t [128];
	typedef logic [G2W-1:0] g2_tab_t [256];

	// 2^(frac/65536) in Q30
	function automatic logic [63:0] exp2_frac_q30(input logic [15:0] frac);
		logic [63:0] m;
		m = 64'd1 << 30;
		for (int k = 0; k < 16; k++) begin
			if (frac[15-k]) m = (m * POW2_FRAC_Q30[k]) >> 30;
		end
		return m;
	endfunction

	// log10 f in Q28 for a point index, index clamped to the last point
	function automatic logic [63:0] point_x(input int idx);
		logic [63:0] c;
		c = (64'(idx) > SPAN) ? SPAN : 64'(idx);
		return (64'd1 << 28) + (LOG10_2000_Q28 * c + SPAN / 2) / SPAN;
	endfunction

	function automatic fq8_tab_t build_fq8_tab();
		fq8_tab_t t;
		logic [63:0] x, l2f, ip;
		for (int i = 0; i < 128; i++) begin
			x = point_x(i);
			l2f = (x * LOG2_10_Q28 + (64'd1 << 39)) >> 40;
			ip = l2f >> 16;
			t[i] = FQW'(exp2_frac_q30(l2f[15:0]) >> (64'd22 - ip));
		end
		return t;
	endfunction

	function automatic lf_tab_t build_lf_tab();
		lf_tab_t t;
		for (int i = 0; i < 128; i++) begin
			t[i] = LFW'((point_x(i) + (64'd1 << 15)) >> 16);
		end
		return t;
	endfunction

	// g^2 = 10^(t/100) in Q16, t in tenths of dB
	function automatic logic [G2W-1:0] g2_of(input longint t);
		longint mag, qm, q, u, sh;
		mag = (t < 0) ? -t : t;
		qm = (mag * longint'(LOG2_10_Q16) + 50) / 100;
		q = (t < 0) ? -qm : qm;
		u = q + (longint'(16) << 16);
		sh = 30 - (u >>> 16);
		return G2W'(exp2_frac_q30(u[15:0]) >> sh);
	endfunction

	function automatic g2_tab_t build_g2_pos();
		g2_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = g2_of(longint'(i));
		return t;
	endfunction

	// entry k serves t = -(k+1), i.e. k = ~t[7:0]
	function automatic g2_tab_t build_g2_neg();
		g2_tab_t t;
		for (int i = 0; i < 256; i++) t[i] = g2_of(-longint'(i) - 1);
		return t;
	endfunction

	localparam fq8_tab_t FQ8_TAB    = build_fq8_tab();
	localparam lf_tab_t  LF_TAB     = build_lf_tab();
	localparam g2_tab_t  G2_POS_TAB = build_g2_pos();
	localparam g2_tab_t  G2_NEG_TAB = build_g2_neg();

	// position of the highest set bit, 0 for zero
	function automatic logic [TBW-1:0] top_bit(input logic [NW-1:0] x);
		logic [TBW-1:0] r;
		r = '0;
		for (int i = 0; i < NW; i++) begin
			if (x[i]) r = TBW'(i);
		end
		return r;
	endfunction

endpackage

// ===== design/teq_in_if.sv =====
// Request channel of the EQ response block: point index and three band gains.
// Depends on teq_pkg.
interface teq_in_if;
	logic valid;
	logic ready;
	logic [teq_pkg::IDXW-1:0] point_index;
	logic signed [teq_pkg::GAINW-1:0] bass_gain_tenth_db;
	logic signed [teq_pkg::GAINW-1:0] mid_gain_tenth_db;
	logic signed [teq_pkg::GAINW-1:0] treble_gain_tenth_db;

	modport source (output valid, point_index, bass_gain_tenth_db, mid_gain_tenth_db,
		treble_gain_tenth_db, input ready);
	modport sink (input valid, point_index, bass_gain_tenth_db, mid_gain_tenth_db,
		treble_gain_tenth_db, output ready);
endinterface

// ===== design/teq_out_if.sv =====
// Result channel of the EQ response block: log frequency and total gain.
// Depends on teq_pkg.
interface teq_out_if;
	logic valid;
	logic ready;
	logic [teq_pkg::LFW-1:0] log_frequency;
	logic signed [teq_pkg::RESPW-1:0] response_centi_db;

	modport source (output valid, log_frequency, response_centi_db, input ready);
	modport sink (input valid, log_frequency, response_centi_db, output ready);
endinterface

// ===== design/three_band_peaking_eq_response_top.sv =====
// Three-band peaking EQ magnitude response, one plot point per item.
// The pipeline has 29 register stages.
// Throughput one item per cycle. The length is set by the two log2 units per band,
// 16 squaring stages each.
// The whole pipe stalls together while the output register holds an untaken item.
// Reset (arst_n, async, low) clears all valid bits and loads the default band settings.
module three_band_peaking_eq_response_top (
	input  logic clk,
	input  logic arst_n,
	teq_in_if.sink   in_ch,
	teq_out_if.source out_ch,
	input  logic write_en,
	input  logic [teq_pkg::CFG_IW-1:0] write_index,
	input  logic [teq_pkg::CFG_DW-1:0] write_data
);

	// band settings
	logic [teq_pkg::FCW-1:0] fc_q [teq_pkg::NSEC];
	logic [teq_pkg::BWW-1:0] bw_q [teq_pkg::NSEC];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q[0] <= teq_pkg::BASS_CENTER_RST;
			bw_q[0] <= teq_pkg::BASS_WIDTH_RST;
			fc_q[1] <= teq_pkg::MID_CENTER_RST;
			bw_q[1] <= teq_pkg::MID_WIDTH_RST;
			fc_q[2] <= teq_pkg::TREBLE_CENTER_RST;
			bw_q[2] <= teq_pkg::TREBLE_WIDTH_RST;
		end else if (write_en) begin
			unique case (write_index)
				teq_pkg::REG_BASS_CENTER:   fc_q[0] <= teq_pkg::FCW'(write_data[8:0]);
				teq_pkg::REG_BASS_WIDTH:    bw_q[0] <= teq_pkg::BWW'(write_data[9:0]);
				teq_pkg::REG_MID_CENTER:    fc_q[1] <= teq_pkg::FCW'(write_data[9:0]);
				teq_pkg::REG_MID_WIDTH:     bw_q[1] <= teq_pkg::BWW'(write_data[12:0]);
				teq_pkg::REG_TREBLE_CENTER: fc_q[2] <= write_data[14:0];
				teq_pkg::REG_TREBLE_WIDTH:  bw_q[2] <= write_data;
				default: ;
			endcase
		end
	end

	// global stall: everything moves unless the output holds an untaken item
	logic adv;
	logic vld_sn [1:teq_pkg::LAST];
	assign adv = !vld_sn[teq_pkg::LAST] || out_ch.ready;
	assign in_ch.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= teq_pkg::LAST; i++) vld_sn[i] <= 1'b0;
		end else if (adv) begin
			vld_sn[1] <= in_ch.valid;
			for (int i = 2; i <= teq_pkg::LAST; i++) vld_sn[i] <= vld_sn[i-1];
		end
	end

	// log frequency rides along untouched
	logic [teq_pkg::LFW-1:0] lf_sn [1:teq_pkg::LAST];
	always_ff @(posedge clk) begin
		if (adv) begin
			lf_sn[1] <= teq_pkg::LF_TAB[in_ch.point_index];
			for (int i = 2; i <= teq_pkg::LAST; i++) lf_sn[i] <= lf_sn[i-1];
		end
	end

	// S1: table lookups for point frequency and band gains
	logic [teq_pkg::FQW-1:0] fq8_s1;
	logic [teq_pkg::G2W-1:0] g2_s1 [teq_pkg::NSEC];
	logic [teq_pkg::GAINW-1:0] gain [teq_pkg::NSEC];
	assign gain[0] = in_ch.bass_gain_tenth_db;
	assign gain[1] = in_ch.mid_gain_tenth_db;
	assign gain[2] = in_ch.treble_gain_tenth_db;

	// per-band payload stages
	logic [teq_pkg::G2W-1:0] g2_s2 [teq_pkg::NSEC], g2_s3 [teq_pkg::NSEC];
	logic [teq_pkg::G2W-1:0] g2_s4 [teq_pkg::NSEC], g2_s5 [teq_pkg::NSEC];
	logic [teq_pkg::G2W-1:0] g2_s6 [teq_pkg::NSEC];
	logic [teq_pkg::DW-1:0] fc2_s2 [teq_pkg::NSEC];
	logic [teq_pkg::DW-1:0] f2_s2;
	logic [teq_pkg::PW-1:0] p_s2 [teq_pkg::NSEC], p_s3 [teq_pkg::NSEC], p_s4 [teq_pkg::NSEC];
	logic [teq_pkg::DW-1:0] d_s3 [teq_pkg::NSEC], d_s4 [teq_pkg::NSEC];
	logic [teq_pkg::PW-1:0] mx_s3 [teq_pkg::NSEC];
	logic [teq_pkg::TBW-1:0] sh_s4 [teq_pkg::NSEC];
	logic [teq_pkg::NRMW-1:0] d_s5 [teq_pkg::NSEC], p_s5 [teq_pkg::NSEC];
	logic [teq_pkg::SQW-1:0] a_s6 [teq_pkg::NSEC], b_s6 [teq_pkg::NSEC], a_s7 [teq_pkg::NSEC];
	logic [teq_pkg::DENW-1:0] den_s7 [teq_pkg::NSEC];
	logic [teq_pkg::NW-1:0] bg_s7 [teq_pkg::NSEC];
	logic [teq_pkg::NSEC-1:0] zero_sn [7:26];
	logic [teq_pkg::NW-1:0] x_s8 [teq_pkg::NLANE], x_s9 [teq_pkg::NLANE];
	logic [teq_pkg::TBW-1:0] tb_s9 [teq_pkg::NLANE];
	logic [teq_pkg::MW-1:0] sqm_sn [0:teq_pkg::NSQ][teq_pkg::NLANE];
	logic [teq_pkg::FRW-1:0] fr_sn [0:teq_pkg::NSQ][teq_pkg::NLANE];
	logic [teq_pkg::TBW-1:0] tb_sn [0:teq_pkg::NSQ][teq_pkg::NLANE];

	function automatic logic [teq_pkg::DW-1:0] d_s3_in(input logic [teq_pkg::DW-1:0] a,
		input logic [teq_pkg::DW-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			// S1
			fq8_s1 <= teq_pkg::FQ8_TAB[in_ch.point_index];
			for (int j = 0; j < teq_pkg::NSEC; j++) begin
				g2_s1[j] <= gain[j][8] ? teq_pkg::G2_NEG_TAB[~gain[j][7:0]]
					: teq_pkg::G2_POS_TAB[gain[j][7:0]];
			end
			// S2: squares and bandwidth product, all Q16 Hz^2
			f2_s2 <= teq_pkg::DW'(fq8_s1 * fq8_s1);
			for (int j = 0; j < teq_pkg::NSEC; j++) begin
				fc2_s2[j] <= {(fc_q[j] == '0) ? 30'd1 : 30'(fc_q[j] * fc_q[j]), 16'd0};
				p_s2[j] <= {39'(bw_q[j] * fq8_s1), 8'd0};
				g2_s2[j] <= g2_s1[j];
			end
			for (int j = 0; j < teq_pkg::NSEC; j++) begin
				// S3: distance from centre, larger term
				d_s3[j] <= (fc2_s2[j] > f2_s2) ? fc2_s2[j] - f2_s2 : f2_s2 - fc2_s2[j];
				mx_s3[j] <= (teq_pkg::PW'(d_s3_in(fc2_s2[j], f2_s2)) > p_s2[j])
					? teq_pkg::PW'(d_s3_in(fc2_s2[j], f2_s2)) : p_s2[j];
				p_s3[j] <= p_s2[j];
				g2_s3[j] <= g2_s2[j];
				// S4: shift to keep both terms within 18 bits
				sh_s4[j] <= (mx_s3[j] >= (teq_pkg::PW'(1) << 18))
					? teq_pkg::top_bit(teq_pkg::NW'(mx_s3[j])) - teq_pkg::TBW'(17) : '0;
				d_s4[j] <= d_s3[j];
				p_s4[j] <= p_s3[j];
				g2_s4[j] <= g2_s3[j];
				// S5
				d_s5[j] <= teq_pkg::NRMW'(d_s4[j] >> sh_s4[j]);
				p_s5[j] <= teq_pkg::NRMW'(p_s4[j] >> sh_s4[j]);
				g2_s5[j] <= g2_s4[j];
				// S6
				a_s6[j] <= d_s5[j] * d_s5[j];
				b_s6[j] <= p_s5[j] * p_s5[j];
				g2_s6[j] <= g2_s5[j];
				// S7
				den_s7[j] <= {37'(a_s6[j] + b_s6[j]), 16'd0};
				bg_s7[j] <= teq_pkg::NW'(b_s6[j] * g2_s6[j]);
				a_s7[j] <= a_s6[j];
				zero_sn[7][j] <= (a_s6[j] == '0) && (b_s6[j] == '0);
				// S8: numerator and denominator become two log lanes
				x_s8[2*j]   <= teq_pkg::NW'({a_s7[j], 16'd0}) + bg_s7[j];
				x_s8[2*j+1] <= teq_pkg::NW'(den_s7[j]);
			end
			for (int i = 8; i <= 26; i++) zero_sn[i] <= zero_sn[i-1];
			// S9: integer part of log2
			for (int l = 0; l < teq_pkg::NLANE; l++) begin
				x_s9[l] <= x_s8[l];
				tb_s9[l] <= teq_pkg::top_bit(x_s8[l]);
				// S10: mantissa in Q30
				sqm_sn[0][l] <= (tb_s9[l] > teq_pkg::TBW'(30))
					? teq_pkg::MW'(x_s9[l] >> (tb_s9[l] - teq_pkg::TBW'(30)))
					: teq_pkg::MW'(x_s9[l] << (teq_pkg::TBW'(30) - tb_s9[l]));
				fr_sn[0][l] <= '0;
				tb_sn[0][l] <= tb_s9[l];
			end
		end
	end

	// S11..S26: one fraction bit per stage by squaring the mantissa
	for (genvar k = 0; k < teq_pkg::NSQ; k++) begin : g_sq
		logic [2*teq_pkg::MW-1:0] mm [teq_pkg::NLANE];
		logic [teq_pkg::MW:0] t [teq_pkg::NLANE];
		always_comb begin
			for (int l = 0; l < teq_pkg::NLANE; l++) begin
				mm[l] = sqm_sn[k][l] * sqm_sn[k][l];
				t[l] = mm[l][2*teq_pkg::MW-1:30];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < teq_pkg::NLANE; l++) begin
					sqm_sn[k+1][l] <= t[l][teq_pkg::MW] ? t[l][teq_pkg::MW:1]
						: t[l][teq_pkg::MW-1:0];
					fr_sn[k+1][l] <= {fr_sn[k][l][teq_pkg::FRW-2:0], t[l][teq_pkg::MW]};
					tb_sn[k+1][l] <= tb_sn[k][l];
				end
			end
		end
	end

	// S27: per band log2 ratio of the S26 lanes, summed
	logic signed [teq_pkg::SECW-1:0] sec [teq_pkg::NSEC];
	logic signed [teq_pkg::SUMW-1:0] sum_s27;
	always_comb begin
		for (int j = 0; j < teq_pkg::NSEC; j++) begin
			sec[j] = zero_sn[26][j] ? '0
				: $signed({1'b0, tb_sn[teq_pkg::NSQ][2*j], fr_sn[teq_pkg::NSQ][2*j]})
				- $signed({1'b0, tb_sn[teq_pkg::NSQ][2*j+1], fr_sn[teq_pkg::NSQ][2*j+1]});
		end
	end

	// S28: scale to centi-dB; S29: round, clip, sign
	logic [teq_pkg::SUMW-2:0] smag;
	logic [teq_pkg::CPW-1:0] prod_s28;
	logic neg_s28;
	logic [teq_pkg::CMW-1:0] cmag;
	logic signed [teq_pkg::RESPW-1:0] resp_s29;
	assign smag = (teq_pkg::SUMW-1)'(sum_s27[teq_pkg::SUMW-1] ? -sum_s27 : sum_s27);
	assign cmag = teq_pkg::CMW'((prod_s28 + teq_pkg::CENTI_RND) >> 32);

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s27 <= teq_pkg::SUMW'(sec[0]) + teq_pkg::SUMW'(sec[1]) + teq_pkg::SUMW'(sec[2]);
			prod_s28 <= teq_pkg::CPW'(smag * teq_pkg::CENTI_PER_L2);
			neg_s28 <= sum_s27[teq_pkg::SUMW-1];
			resp_s29 <= neg_s28
				? -teq_pkg::RESPW'((cmag > teq_pkg::SAT_CENTI) ? teq_pkg::SAT_CENTI : cmag)
				: teq_pkg::RESPW'((cmag > teq_pkg::SAT_CENTI) ? teq_pkg::SAT_CENTI : cmag);
		end
	end

	assign out_ch.valid = vld_sn[teq_pkg::LAST];
	assign out_ch.log_frequency = lf_sn[teq_pkg::LAST];
	assign out_ch.response_centi_db = resp_s29;

endmodule
